// ----- design/xorshift_weight_perturber_top_defines.svh -----
// Assertion macros shared by the xorshift weight perturber RTL.
`ifndef XORSHIFT_WEIGHT_PERTURBER_TOP_DEFINES_SVH
`define XORSHIFT_WEIGHT_PERTURBER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define XWP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xwp assertion failed");

// Next-cycle implication, checked out of reset.
`define XWP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xwp assertion failed");

`endif

// ----- design/xwp_pkg.sv -----
// Types and constants for the xorshift weight perturber.
package xwp_pkg;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    localparam int XS_SHL_A = 13;
    localparam int XS_SHR_B = 17;
    localparam int XS_SHL_C = 5;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SEED       = 2'd0,
        REG_DIRECTION  = 2'd1,
        REG_NOISE_MODE = 2'd2,
        REG_EPSILON    = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_UNIFORM    = 2'd0,
        MODE_TRIANGULAR = 2'd1,
        MODE_RADEMACHER = 2'd2,
        MODE_BATCHED    = 2'd3
    } t_noise_mode;

    typedef struct packed {
        logic signed [31:0] weight;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] perturbed_weight;
        logic               last_out;
        logic               saturated;
    } t_out_item;

    function automatic logic [31:0] xs_step(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << XS_SHL_A);
        t = t ^ (t >> XS_SHR_B);
        t = t ^ (t << XS_SHL_C);
        return t;
    endfunction

endpackage

// ----- design/xorshift_weight_perturber_top.sv -----
// Top level of the xorshift weight perturber: noise generator, multiplier, saturating add.
//
// Usage:
// - Input channel (i_in_valid / o_in_stall / i_in_data) carries one Q16.16 weight and a
//   last mark per transfer; the item with last set closes a vector, and the next item
//   reseeds the noise generator from the seed register.
// - Output channel (o_out_valid / i_out_stall / o_out_data) returns one perturbed weight
//   per input, in order, with last_out and a saturation flag.
// - Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is always
//   ready; write it only while no items are in flight. Seed takes effect at the next
//   vector start, the other registers from the next item.
// - Pipeline: an input transfer passes the generator stage, the multiplier stage and the
//   add/saturate into the output register before its result can transfer.
// - Throughput: one item per cycle while the output is not stalled. The xorshift state
//   update (reseed, up to two steps) is combinational; the 33x33 multiply has its own stage.
// - Output stall: stages hold and bubbles collapse; o_in_stall rises only when all three
//   stages are full and the output is stalled.
// - Reset (i_rst_n low, synchronous): pipeline emptied, registers return to seed 0,
//   direction 1, uniform mode, epsilon 0; the first item starts a new vector.
module xorshift_weight_perturber_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  xwp_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output xwp_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import xwp_pkg::*;

    // Configuration
    logic [31:0]        r_seed_lcg;
    logic [31:0]        n_seed_lcg;
    logic               r_direction;
    t_noise_mode        r_mode;
    logic signed [31:0] r_epsilon;

    // Generator state
    logic [31:0] r_rng;
    logic        r_vec_start;
    logic [4:0]  r_bidx;

    // Stage 1: multiplier operands
    logic               r_v1;
    logic signed [32:0] r_opa;
    logic signed [32:0] r_opb;
    logic               r_rad1;
    logic               r_neg1;
    logic signed [31:0] r_w1;
    logic               r_last1;

    // Stage 2: product
    logic               r_v2;
    logic signed [65:0] r_prod;
    logic signed [33:0] r_radn;
    logic               r_rad2;
    logic signed [31:0] r_w2;
    logic               r_last2;

    // Output register
    logic      r_vo;
    t_out_item r_out;

    logic in_acc, move2, move_out, free1, free2, cfg_acc;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign n_seed_lcg  = 32'(i_cfg_data * LCG_MUL) + LCG_ADD;

    assign move_out   = r_v2 && (!r_vo || !i_out_stall);
    assign free2      = !r_v2 || move_out;
    assign move2      = r_v1 && free2;
    assign free1      = !r_v1 || move2;
    assign o_in_stall = !free1;
    assign in_acc     = i_in_valid && free1;

    // ---- generator stage ----
    logic [31:0]        base, x1, x2, n_rng;
    logic [4:0]         bidx, n_bidx;
    logic signed [32:0] n_opb, n_e, eps_ext;
    logic               n_rad, n_bit;

    always_comb begin
        base    = r_vec_start ? r_seed_lcg : r_rng;
        bidx    = r_vec_start ? 5'd0 : r_bidx;
        x1      = xs_step(base);
        x2      = xs_step(x1);
        eps_ext = {r_epsilon[31], r_epsilon};
        n_e     = r_direction ? eps_ext : -eps_ext;
        n_bidx  = bidx;
        n_rad   = 1'b0;
        n_bit   = 1'b0;
        n_rng   = x1;
        n_opb   = $signed({1'b0, x1}) - $signed({2'b01, 31'd0});
        case (r_mode)
            MODE_UNIFORM: begin
                n_rng = x1;
            end
            MODE_TRIANGULAR: begin
                n_rng = x2;
                n_opb = $signed({1'b0, x1}) - $signed({1'b0, x2});
            end
            MODE_RADEMACHER: begin
                n_rng = x1;
                n_rad = 1'b1;
                n_bit = x1[0];
            end
            default: begin
                n_rng  = (bidx == 5'd0) ? x1 : base;
                n_rad  = 1'b1;
                n_bit  = n_rng[bidx];
                n_bidx = bidx + 5'd1;
            end
        endcase
    end

    // ---- add and saturate ----
    logic signed [33:0] noise_mul, noise;
    logic signed [34:0] sum;
    logic               sat;
    logic signed [31:0] sum_clip;

    always_comb begin
        noise_mul = $signed(r_prod[65:32]) + $signed({33'd0, r_prod[31]});
        noise     = r_rad2 ? r_radn : noise_mul;
        sum       = {{3{r_w2[31]}}, r_w2} + {noise[33], noise};
        sat       = !((sum[34:31] == 4'b0000) || (sum[34:31] == 4'b1111));
        if (!sat) begin
            sum_clip = sum[31:0];
        end else if (sum[34]) begin
            sum_clip = {1'b1, 31'd0};
        end else begin
            sum_clip = {1'b0, {31{1'b1}}};
        end
    end

    // Control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_lcg  <= LCG_ADD;
            r_direction <= 1'b1;
            r_mode      <= MODE_UNIFORM;
            r_epsilon   <= '0;
            r_rng       <= '0;
            r_vec_start <= 1'b1;
            r_bidx      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_vo        <= 1'b0;
        end else begin
            if (cfg_acc) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_SEED:       r_seed_lcg  <= n_seed_lcg;
                    REG_DIRECTION:  r_direction <= i_cfg_data[0];
                    REG_NOISE_MODE: r_mode      <= t_noise_mode'(i_cfg_data[1:0]);
                    REG_EPSILON:    r_epsilon   <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_rng       <= n_rng;
                r_bidx      <= n_bidx;
                r_vec_start <= i_in_data.last;
            end
            r_v1 <= in_acc || (r_v1 && !move2);
            r_v2 <= move2 || (r_v2 && !move_out);
            r_vo <= move_out || (r_vo && i_out_stall);
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_opa   <= n_e;
            r_opb   <= n_opb;
            r_rad1  <= n_rad;
            r_neg1  <= !n_bit;
            r_w1    <= i_in_data.weight;
            r_last1 <= i_in_data.last;
        end
        if (move2) begin
            r_prod  <= r_opa * r_opb;
            r_radn  <= r_neg1 ? -{r_opa[32], r_opa} : {r_opa[32], r_opa};
            r_rad2  <= r_rad1;
            r_w2    <= r_w1;
            r_last2 <= r_last1;
        end
        if (move_out) begin
            r_out.perturbed_weight <= sum_clip;
            r_out.last_out         <= r_last2;
            r_out.saturated        <= sat;
        end
    end

    assign o_out_valid = r_vo;
    assign o_out_data  = r_out;

`include "xorshift_weight_perturber_top_defines.svh"

    `XWP_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, in_acc && i_in_data.last, r_vec_start)
    `XWP_ASSERT_NEXT(a_batch_index_steps, i_clk, i_rst_n,
        in_acc && (r_mode == MODE_BATCHED) && !r_vec_start, r_bidx == 5'($past(r_bidx) + 5'd1))
    `XWP_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, r_v1 && r_v2 && r_vo)
    `XWP_ASSERT_NOW(a_sat_clamps, i_clk, i_rst_n, o_out_valid && o_out_data.saturated,
        (o_out_data.perturbed_weight == {1'b1, 31'd0}) ||
        (o_out_data.perturbed_weight == {1'b0, {31{1'b1}}}))

endmodule
